// File: rtl/core/pgenc_pkg.sv
// Shared types, constants and the byte classifier for the packed 64-bit encoder.
// No dependencies; every module of the encoder imports this package.
package pgenc_pkg;

    localparam int VALUE_W     = 64;
    localparam int BYTE_W      = 8;
    localparam int NUM_BYTES   = VALUE_W / BYTE_W;
    localparam int MASK_W      = NUM_BYTES;
    localparam int BIDX_W      = $clog2(NUM_BYTES);
    localparam int CNT_W       = $clog2(NUM_BYTES);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;

    // One classified item: the raw value and its mask byte.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [MASK_W-1:0]  mask;
    } entry_t;

    // Build the mask: bit 0 flags an all-ones default, bit k flags byte k sent.
    function automatic logic [MASK_W-1:0] classify(input logic [VALUE_W-1:0] value);
        logic [CNT_W-1:0]  ones;
        logic [CNT_W-1:0]  zeros;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] dflt;
        logic [MASK_W-1:0] mask;
        ones  = '0;
        zeros = '0;
        for (int k = 1; k < NUM_BYTES; k++)
        begin
            b = value[k*BYTE_W +: BYTE_W];
            if (b == BYTE_ONES)
                ones = ones + CNT_W'(1);
            else if (b == BYTE_ZERO)
                zeros = zeros + CNT_W'(1);
        end
        dflt    = (zeros < ones) ? BYTE_ONES : BYTE_ZERO;
        mask    = '0;
        mask[0] = (zeros < ones);
        for (int k = 1; k < NUM_BYTES; k++)
        begin
            mask[k] = (value[k*BYTE_W +: BYTE_W] != dflt);
        end
        return mask;
    endfunction

endpackage

// File: rtl/core/pgenc_front.sv
// Front end: accepts input words, classifies the upper bytes, pushes entries.
// Depends on pgenc_pkg.
module pgenc_front
    import pgenc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,    // [63:0] value
    output logic               push_valid,
    input  logic               push_ready,
    output entry_t             push_entry
);

    logic   vld_reg;
    logic   vld_next;
    entry_t ent_reg;
    logic   take;

    // Register stage: refill while the held entry drains.
    assign s_tready = !vld_reg || push_ready;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        vld_next = vld_reg;
        if (take)
            vld_next = 1'b1;
        else if (push_ready)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ent_reg.value <= s_tdata;
            ent_reg.mask  <= classify(s_tdata);
        end
    end

    assign push_valid = vld_reg;
    assign push_entry = ent_reg;

endmodule

// File: rtl/core/pgenc_queue.sv
// Short queue of classified entries between front and back end.
// Depends on pgenc_pkg.
module pgenc_queue
    import pgenc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  entry_t in_entry,
    output logic   out_valid,
    input  logic   out_ready,
    output entry_t out_entry
);

    entry_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  cnt_reg;
    logic [QCNT_W-1:0]  cnt_next;
    logic               wr_en;
    logic               rd_en;

    assign in_ready  = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign wr_en     = in_valid && in_ready;
    assign rd_en     = out_valid && out_ready;
    assign out_entry = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (rd_en && !wr_en)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + QPTR_W'(1);
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + QPTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= in_entry;
    end

endmodule

// File: rtl/core/pgenc_back.sv
// Back end: serializes one entry into mask, low byte and sent upper bytes.
// Depends on pgenc_pkg.
module pgenc_back
    import pgenc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  entry_t            pop_entry,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,    // [7:0] out_byte
    output logic              m_tlast
);

    localparam logic [1:0] PH_MASK  = 2'd0;
    localparam logic [1:0] PH_LOW   = 2'd1;
    localparam logic [1:0] PH_UPPER = 2'd2;

    logic                busy_reg;
    logic                busy_next;
    logic [1:0]          phase_reg;
    logic [1:0]          phase_next;
    logic [VALUE_W-1:0]  val_reg;
    logic [MASK_W-1:0]   mask_reg;
    logic [MASK_W-2:0]   rem_reg;
    logic [MASK_W-2:0]   rem_next;
    logic [MASK_W-2:0]   rem_clr;
    logic                out_vld_reg;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic                out_last_reg;

    logic                out_adv;
    logic                load;
    logic [BIDX_W-1:0]   sel_idx;
    logic [BYTE_W-1:0]   gen_byte;
    logic                gen_last;

    assign out_adv   = !out_vld_reg || m_tready;
    assign pop_ready = out_adv && (!busy_reg || gen_last);
    assign load      = pop_valid && pop_ready;
    assign rem_clr   = rem_reg & (rem_reg - (MASK_W-1)'(1));

    // Lowest pending upper byte; rem bit j stands for byte j+1.
    always_comb
    begin
        sel_idx = BIDX_W'(1);
        for (int j = MASK_W - 2; j >= 0; j--)
        begin
            if (rem_reg[j])
                sel_idx = BIDX_W'(j + 1);
        end
    end

    always_comb
    begin
        gen_byte   = mask_reg;
        gen_last   = 1'b0;
        phase_next = phase_reg;
        rem_next   = rem_reg;
        case (phase_reg)
            PH_MASK:
            begin
                gen_byte   = mask_reg;
                gen_last   = 1'b0;
                phase_next = PH_LOW;
            end
            PH_LOW:
            begin
                gen_byte   = val_reg[BYTE_W-1:0];
                gen_last   = (rem_reg == '0);
                phase_next = PH_UPPER;
            end
            PH_UPPER:
            begin
                gen_byte = val_reg[{sel_idx, 3'b000} +: BYTE_W];
                gen_last = (rem_clr == '0);
                rem_next = rem_clr;
            end
            default:
            begin
                gen_byte   = mask_reg;
                gen_last   = 1'b0;
                phase_next = PH_LOW;
            end
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (load)
            busy_next = 1'b1;
        else if (busy_reg && out_adv && gen_last)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            phase_reg   <= PH_MASK;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (load)
                phase_reg <= PH_MASK;
            else if (busy_reg && out_adv)
                phase_reg <= phase_next;
            if (out_adv)
                out_vld_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            val_reg  <= pop_entry.value;
            mask_reg <= pop_entry.mask;
            rem_reg  <= pop_entry.mask[MASK_W-1:1];
        end
        else if (busy_reg && out_adv)
        begin
            rem_reg <= rem_next;
        end
        if (busy_reg && out_adv)
        begin
            out_byte_reg <= gen_byte;
            out_last_reg <= gen_last;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/core/packed_u64_default_byte_encoder.sv
// Top level of the packed 64-bit default-byte encoder.
// Depends on pgenc_pkg, pgenc_front, pgenc_queue and pgenc_back.
//
//   channel   dir   handshake            payload
//   s_*       in    s_tvalid/s_tready    s_tdata[63:0] value
//   m_*       out   m_tvalid/m_tready    m_tdata[7:0] out_byte, m_tlast last
//
// Each word in yields 2 to 9 bytes out. The back-end serializer sends one byte
// per cycle while m_tready allows and loads the next word as it emits the last
// byte of the current one. Words pass the front, queue and back-end registers.
// Reset clears all handshake state; payload registers are not reset.
// The front register and a two-entry queue let input words keep arriving
// while the output is stalled; the output register holds its byte under stall.
module packed_u64_default_byte_encoder
    import pgenc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,    // [63:0] value
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [BYTE_W-1:0]  m_tdata,    // [7:0] out_byte
    output logic               m_tlast
);

    logic   push_valid;
    logic   push_ready;
    entry_t push_entry;
    logic   pop_valid;
    logic   pop_ready;
    entry_t pop_entry;

    // Classify each accepted word into its mask byte.
    pgenc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // Decouple classification from serialization.
    pgenc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_entry  (push_entry),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_entry (pop_entry)
    );

    // Emit mask, low byte, then each non-default upper byte in ascending order.
    pgenc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// File: bench/tb_packed_u64_default_byte_encoder.sv
// Self-checking bench for packed_u64_default_byte_encoder: streams 64-bit words in and
// checks every mask and payload byte (with tlast) against an in-bench encoder.
// Depends on pgenc_pkg and the encoder RTL; nothing else.
module tb_packed_u64_default_byte_encoder;

    import pgenc_pkg::*;

    // Cycles without any handshake before the run is declared hung. The worst
    // honest stall is a long run of refused ready at 73% idling plus the fill
    // of the front, queue and back-end registers, far below this.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles to linger once every expected byte has arrived, to catch extras.
    localparam int TAIL_CYCLES    = 20;
    localparam int RANDOM_WORDS   = 144;
    localparam int MAX_REPORTS    = 10;

    // One encoded byte as it should leave the block.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } enc_byte_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [VALUE_W-1:0] s_tdata  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [BYTE_W-1:0]  m_tdata;
    logic               m_tlast;

    logic [VALUE_W-1:0] pending_values [$];   // words not yet offered to the block
    enc_byte_t          expected_bytes [$];   // encoded bytes still owed by the block

    int unsigned src_idle_pct  = 6;
    int unsigned sink_idle_pct = 73;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;
    logic        word_taken     = 1'b0;       // s_* handshake at the last rising edge

    packed_u64_default_byte_encoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),     // [63:0] value
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),     // [7:0] out_byte
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Encode one word into the byte stream the block should produce: mask,
    // byte 0, then every upper byte that differs from the chosen default.
    function automatic void encode_value(input logic [VALUE_W-1:0] value);
        logic [BYTE_W-1:0] lane;
        logic [BYTE_W-1:0] fill;
        logic [BYTE_W-1:0] mask;
        logic [BYTE_W-1:0] kept [$];
        int                ones;
        int                zeros;
        ones  = 0;
        zeros = 0;
        for (int k = 1; k < NUM_BYTES; k++)
        begin
            lane = value[k*BYTE_W +: BYTE_W];
            if (lane == BYTE_ONES)
                ones++;
            else if (lane == BYTE_ZERO)
                zeros++;
        end
        // A tie, zero counts included, falls to the all-zero default.
        fill = (zeros < ones) ? BYTE_ONES : BYTE_ZERO;
        mask = '0;
        mask[0] = (fill == BYTE_ONES);
        for (int k = 1; k < NUM_BYTES; k++)
        begin
            lane = value[k*BYTE_W +: BYTE_W];
            if (lane != fill)
            begin
                kept.push_back(lane);
                mask[k] = 1'b1;
            end
        end
        expected_bytes.push_back('{out_byte: mask, last: 1'b0});
        // Byte 0 closes the word when no upper byte survives.
        expected_bytes.push_back('{out_byte: value[BYTE_W-1:0], last: kept.size() == 0});
        for (int i = 0; i < kept.size(); i++)
            expected_bytes.push_back('{out_byte: kept[i], last: i == kept.size() - 1});
    endfunction

    // Most words are built lane by lane from 00, FF and random bytes so that
    // ties, both defaults and all-default words come up often; the rest are
    // fully random and mostly send every byte.
    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] value;
        if ($urandom_range(9) < 2)
            return {$urandom, $urandom};
        for (int k = 0; k < NUM_BYTES; k++)
        begin
            case ($urandom_range(2))
                0:       value[k*BYTE_W +: BYTE_W] = BYTE_ZERO;
                1:       value[k*BYTE_W +: BYTE_W] = BYTE_ONES;
                default: value[k*BYTE_W +: BYTE_W] = BYTE_W'($urandom);
            endcase
        end
        return value;
    endfunction

    // Hold until every queued word is taken and every owed byte has come out.
    task automatic wait_drained();
        while (pending_values.size() != 0 || s_tvalid || expected_bytes.size() != 0)
            @(negedge clk);
    endtask

    // Driver: change inputs on the falling edge. Offer the next word once the
    // current one is taken, or drop valid at random to leave the source idle.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || word_taken)
            begin
                if (pending_values.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_values.pop_front();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Monitor: sample both handshakes on the rising edge, predict on input,
    // compare on output, and run the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            word_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                encode_value(s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected byte: out_byte=%h last=%b", m_tdata, m_tlast);
                end
                else
                begin
                    enc_byte_t want;
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.out_byte || m_tlast !== want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("byte mismatch: expected %h/%b, got %h/%b",
                                     want.out_byte, want.last, m_tdata, m_tlast);
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        // Corner words: both extremes, ties with and without counted bytes,
        // a one-vote win for the all-ones default, default bytes at either end,
        // and words with no default byte at all.
        pending_values = '{
            64'h0000_0000_0000_0000,
            64'hFFFF_FFFF_FFFF_FFFF,
            64'hFFFF_FFFF_FFFF_FF00,
            64'h0000_0000_0000_00FF,
            64'h0123_4567_89AB_CDEF,
            64'hFEDC_BA98_7654_3210,
            64'hFF00_FF00_FF00_1234,
            64'h0102_0304_0506_0708,
            64'hFFFF_00FF_0000_FF55,
            64'hFF00_0000_0000_00FF,
            64'h00FF_FFFF_FFFF_FFFF,
            64'h8000_0000_0000_0080,
            64'h7F7F_7F7F_7F7F_7F7F,
            64'hAAAA_AAAA_AAAA_AAAA,
            64'h5555_5555_5555_5555,
            64'h0000_0000_0000_FF00,
            64'hFFFF_FFFF_FFFF_00FF
        };
        for (int i = 0; i < RANDOM_WORDS / 3; i++)
            pending_values.push_back(random_value());

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Phase one: sparse source gaps, heavy sink backpressure.
        wait_drained();

        // Phase two: swap the roles after a full drain.
        src_idle_pct  = 73;
        sink_idle_pct = 6;
        for (int i = 0; i < RANDOM_WORDS / 3; i++)
            pending_values.push_back(random_value());
        wait_drained();

        // Phase three: both sides at full rate.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        for (int i = 0; i < RANDOM_WORDS - 2 * (RANDOM_WORDS / 3); i++)
            pending_values.push_back(random_value());
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_bytes.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/pgenc_pkg.sv
rtl/core/pgenc_front.sv
rtl/core/pgenc_queue.sv
rtl/core/pgenc_back.sv
rtl/core/packed_u64_default_byte_encoder.sv
bench/tb_packed_u64_default_byte_encoder.sv
